[rtl/core/pendulum_rope_particle_step_defines.svh]
// Assertion macros shared by the rope particle RTL.
`ifndef PENDULUM_ROPE_PARTICLE_STEP_DEFINES_SVH
`define PENDULUM_ROPE_PARTICLE_STEP_DEFINES_SVH

`ifndef ASSERT_OFF
`define PRP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PRP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/prp_pkg.sv]
`timescale 1ns / 1ps
package prp_pkg;

	localparam logic [30:0] GRAVITY_RST = 31'd4915200;
	localparam logic [30:0] ROPE_RST    = 31'd2048000;
	localparam logic [15:0] DAMP_RST    = 16'd64881;
	localparam logic signed [31:0] POS_Y_RST = 32'sd491520;

	localparam logic [1:0] CFG_GRAVITY = 2'd0;
	localparam logic [1:0] CFG_ROPE    = 2'd1;
	localparam logic [1:0] CFG_DAMP    = 2'd2;

	function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh000000007FFFFFFF) begin
			return 32'sh7FFFFFFF;
		end else if (v < 64'shFFFFFFFF80000000) begin
			return 32'sh80000000;
		end else begin
			return $signed(v[31:0]);
		end
	endfunction

endpackage

[rtl/core/pendulum_rope_particle_step.sv]
`timescale 1ns / 1ps
`include "pendulum_rope_particle_step_defines.svh"
// Rope-bound particle: one damped Euler step per input word.
// Input channel (in_valid/in_stall) carries dt and the anchor position;
// the block answers with one output word (out_valid/out_stall) holding the
// new position, velocity and the rope_taut flag.
// An item is worked on from acceptance until out_valid; when the rope is
// slack the square root, the divisions and the rope fix are skipped. The
// block takes the next word only after that. Work runs on the single shared
// 35x32 multiplier, the 32-step bit-serial square root and two 17-step bit-serial divisions.
// in_stall is high whenever the sequencer is busy.
// A finished word sits in the output register; the next item may be
// accepted and worked on while it waits, and a stalled receiver holds the
// sequencer in its last step until the register frees up.
// Reset (arst_n low) puts the particle at rest 120 units below the origin
// and loads the default gravity, rope length and damping.
// cfg_ready is always high; write registers only while the block is idle.
module pendulum_rope_particle_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        time_step,
	input  logic signed [31:0] anchor_x,
	input  logic signed [31:0] anchor_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] position_x,
	output logic signed [31:0] position_y,
	output logic signed [31:0] velocity_x,
	output logic signed [31:0] velocity_y,
	output logic               rope_taut,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data
);
	import prp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_G, S_VY, S_VX, S_VY2, S_PX, S_PY, S_DIFF, S_SQX, S_SQY, S_LEN,
		S_CMP, S_SQRT, S_DSET, S_DIV, S_PXA, S_PYA, S_DOT1, S_DOT2, S_DOT3,
		S_VXC, S_VYC, S_VEND, S_DONE
	} state_t;

	state_t state_q;
	logic [30:0] grav_q, rope_q;
	logic [15:0] damp_q, dt_q;
	logic signed [31:0] ax_q, ay_q, px_q, py_q, vx_q, vy_q;
	logic signed [63:0] prod_q, acc_q;
	logic [30:0] ux_q, uy_q;
	logic sx_q, sy_q, big_q, taut_q;
	logic [63:0] sqv_q;
	logic [35:0] srem_q;
	logic [31:0] root_q, d_q, drem_q;
	logic [4:0] cnt_q;
	logic [15:0] quo_q;
	logic dsel_q;
	logic signed [17:0] dirx_q, diry_q;
	logic signed [33:0] dot_q;
	logic signed [31:0] opx_q, opy_q, ovx_q, ovy_q;
	logic otaut_q, out_valid_q;

	logic signed [34:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [66:0] mul_p;
	logic signed [63:0] shr;
	logic signed [32:0] dx, dy, ndx, ndy;
	logic [31:0] magx, magy;
	logic [35:0] srem_n, strial;
	logic sge;
	logic nb, dge;
	logic [32:0] drem_n, dsub;
	logic [16:0] quo_n;
	logic signed [17:0] dir_mag, dir_neg;
	logic signed [63:0] dot_sum, dot_shr;
	logic taut_now;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign position_x = opx_q;
	assign position_y = opy_q;
	assign velocity_x = ovx_q;
	assign velocity_y = ovy_q;
	assign rope_taut  = otaut_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_G: begin
				mul_a = {4'b0, grav_q};
				mul_b = {16'b0, dt_q};
			end
			S_VY: begin
				mul_a = {{3{vx_q[31]}}, vx_q};
				mul_b = {16'b0, damp_q};
			end
			S_VX: begin
				mul_a = {{3{vy_q[31]}}, vy_q};
				mul_b = {16'b0, damp_q};
			end
			S_VY2: begin
				mul_a = {{3{vx_q[31]}}, vx_q};
				mul_b = {16'b0, dt_q};
			end
			S_PX: begin
				mul_a = {{3{vy_q[31]}}, vy_q};
				mul_b = {16'b0, dt_q};
			end
			S_SQX: begin
				mul_a = {4'b0, ux_q};
				mul_b = {1'b0, ux_q};
			end
			S_SQY: begin
				mul_a = {4'b0, uy_q};
				mul_b = {1'b0, uy_q};
			end
			S_LEN: begin
				mul_a = {4'b0, rope_q};
				mul_b = {1'b0, rope_q};
			end
			S_PXA: begin
				mul_a = {4'b0, rope_q};
				mul_b = {{14{dirx_q[17]}}, dirx_q};
			end
			S_PYA: begin
				mul_a = {4'b0, rope_q};
				mul_b = {{14{diry_q[17]}}, diry_q};
			end
			S_DOT1: begin
				mul_a = {{3{vx_q[31]}}, vx_q};
				mul_b = {{14{dirx_q[17]}}, dirx_q};
			end
			S_DOT2: begin
				mul_a = {{3{vy_q[31]}}, vy_q};
				mul_b = {{14{diry_q[17]}}, diry_q};
			end
			S_VXC: begin
				mul_a = {dot_q[33], dot_q};
				mul_b = {{14{dirx_q[17]}}, dirx_q};
			end
			S_VYC: begin
				mul_a = {dot_q[33], dot_q};
				mul_b = {{14{diry_q[17]}}, diry_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign shr   = prod_q >>> 16;

	assign dx   = {px_q[31], px_q} - {ax_q[31], ax_q};
	assign dy   = {py_q[31], py_q} - {ay_q[31], ay_q};
	assign ndx  = -dx;
	assign ndy  = -dy;
	assign magx = dx[32] ? ndx[31:0] : dx[31:0];
	assign magy = dy[32] ? ndy[31:0] : dy[31:0];

	// square root: two radicand bits per cycle
	assign srem_n = {srem_q[33:0], sqv_q[63:62]};
	assign strial = {2'b00, root_q, 2'b01};
	assign sge    = (srem_n >= strial);

	// divide (u << 16) / d: quotient fits 17 bits, only bit 16 of the
	// numerator below u >> 1 can be nonzero
	assign nb      = (dsel_q ? uy_q[0] : ux_q[0]) & (cnt_q == 5'd16);
	assign drem_n  = {drem_q, nb};
	assign dge     = (drem_n >= {1'b0, d_q});
	assign dsub    = drem_n - {1'b0, d_q};
	assign quo_n   = {quo_q, dge};
	assign dir_mag = {1'b0, quo_n};
	assign dir_neg = -dir_mag;

	assign dot_sum  = acc_q + prod_q;
	assign dot_shr  = dot_sum >>> 16;
	assign taut_now = big_q || (acc_q > prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			grav_q      <= GRAVITY_RST;
			rope_q      <= ROPE_RST;
			damp_q      <= DAMP_RST;
			px_q        <= '0;
			py_q        <= POS_Y_RST;
			vx_q        <= '0;
			vy_q        <= '0;
			out_valid_q <= 1'b0;
			taut_q      <= 1'b0;
			cnt_q       <= '0;
			dsel_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GRAVITY: grav_q <= cfg_data;
					CFG_ROPE:    rope_q <= cfg_data;
					CFG_DAMP:    damp_q <= cfg_data[15:0];
					default:     ;
				endcase
			end

			// in S_DONE the output register is reloaded below instead
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			prod_q <= $signed(mul_p[63:0]);

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						dt_q    <= time_step;
						ax_q    <= anchor_x;
						ay_q    <= anchor_y;
						taut_q  <= 1'b0;
						state_q <= S_G;
					end
				end
				S_G: state_q <= S_VY;
				S_VY: begin
					vy_q    <= sat32(sx64(vy_q) + shr);
					state_q <= S_VX;
				end
				S_VX: begin
					vx_q    <= shr[31:0];
					state_q <= S_VY2;
				end
				S_VY2: begin
					vy_q    <= shr[31:0];
					state_q <= S_PX;
				end
				S_PX: begin
					px_q    <= sat32(sx64(px_q) + shr);
					state_q <= S_PY;
				end
				S_PY: begin
					py_q    <= sat32(sx64(py_q) + shr);
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					big_q   <= magx[31] | magy[31];
					ux_q    <= (magx[31] | magy[31]) ? magx[31:1] : magx[30:0];
					uy_q    <= (magx[31] | magy[31]) ? magy[31:1] : magy[30:0];
					sx_q    <= dx[32];
					sy_q    <= dy[32];
					state_q <= S_SQX;
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: begin
					acc_q   <= prod_q;
					state_q <= S_LEN;
				end
				S_LEN: begin
					acc_q   <= acc_q + prod_q;
					state_q <= S_CMP;
				end
				S_CMP: begin
					taut_q <= taut_now;
					sqv_q  <= acc_q;
					srem_q <= '0;
					root_q <= '0;
					cnt_q  <= 5'd31;
					state_q <= taut_now ? S_SQRT : S_DONE;
				end
				S_SQRT: begin
					srem_q <= sge ? (srem_n - strial) : srem_n;
					root_q <= {root_q[30:0], sge};
					sqv_q  <= {sqv_q[61:0], 2'b00};
					cnt_q  <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						state_q <= S_DSET;
					end
				end
				S_DSET: begin
					d_q     <= (root_q == '0) ? 32'd1 : root_q;
					drem_q  <= {2'b00, ux_q[30:1]};
					quo_q   <= '0;
					cnt_q   <= 5'd16;
					dsel_q  <= 1'b0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0 && !dsel_q) begin
						// x done, restart for y
						dirx_q <= sx_q ? dir_neg : dir_mag;
						dsel_q <= 1'b1;
						drem_q <= {2'b00, uy_q[30:1]};
						quo_q  <= '0;
						cnt_q  <= 5'd16;
					end else begin
						drem_q <= dge ? dsub[31:0] : drem_n[31:0];
						quo_q  <= quo_n[15:0];
						cnt_q  <= cnt_q - 5'd1;
						if (cnt_q == '0) begin
							diry_q  <= sy_q ? dir_neg : dir_mag;
							state_q <= S_PXA;
						end
					end
				end
				S_PXA: state_q <= S_PYA;
				S_PYA: begin
					px_q    <= sat32(sx64(ax_q) + shr);
					state_q <= S_DOT1;
				end
				S_DOT1: begin
					py_q    <= sat32(sx64(ay_q) + shr);
					state_q <= S_DOT2;
				end
				S_DOT2: begin
					acc_q   <= prod_q;
					state_q <= S_DOT3;
				end
				S_DOT3: begin
					dot_q   <= dot_shr[33:0];
					state_q <= S_VXC;
				end
				S_VXC: state_q <= S_VYC;
				S_VYC: begin
					vx_q    <= sat32(sx64(vx_q) - shr);
					state_q <= S_VEND;
				end
				S_VEND: begin
					vy_q    <= sat32(sx64(vy_q) - shr);
					state_q <= S_DONE;
				end
				S_DONE: begin
					// wait here while the previous word is still unclaimed
					if (!out_valid_q || !out_stall) begin
						opx_q       <= px_q;
						opy_q       <= py_q;
						ovx_q       <= vx_q;
						ovy_q       <= vy_q;
						otaut_q     <= taut_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PRP_ASSERT_NEXT(a_accept_start, clk, arst_n, in_valid && !in_stall, state_q == S_G)
	`PRP_ASSERT_IMPL(a_sqrt_taut, clk, arst_n, state_q == S_SQRT, taut_q)
	`PRP_ASSERT_IMPL(a_div_nonzero, clk, arst_n, state_q == S_DIV, d_q != '0)

endmodule

[dv/pendulum_rope_particle_step_test.sv]
`timescale 1ns / 1ps
module pendulum_rope_particle_step_test;
	import prp_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned STALL_LIMIT = 3000;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic               taut;
	} particle_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [15:0]        time_step = '0;
	logic signed [31:0] anchor_x = '0;
	logic signed [31:0] anchor_y = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] position_x;
	logic signed [31:0] position_y;
	logic signed [31:0] velocity_x;
	logic signed [31:0] velocity_y;
	logic               rope_taut;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [30:0]        cfg_data = '0;

	pendulum_rope_particle_step uut (.*);

	// predictor copy of registers and particle state
	logic [30:0]        gravity_q;
	logic [30:0]        rope_q;
	logic [15:0]        damp_q;
	logic signed [31:0] px_q, py_q, vx_q, vy_q;

	particle_t   expected_q[$];
	int          fails = 0;
	bit          gaps_on = 1'b0;
	int unsigned idle_cnt = 0;
	int          stall_cnt = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -64'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic bit [63:0] root64(input bit [63:0] v);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// one damped Euler step plus rope constraint; updates the particle state
	function automatic particle_t swing_step(input logic [15:0] dt,
			input logic signed [31:0] ax, input logic signed [31:0] ay);
		longint vx, vy, px, py, dx, dy, dirx, diry, dot, g, ldt;
		bit [63:0] ux, uy, d, len;
		logic taut;
		particle_t r;
		ldt = longint'({48'd0, dt});
		len = {33'd0, rope_q};
		g = longint'(({33'd0, gravity_q} * {48'd0, dt}) >> 16);
		vy = clamp32(longint'(vy_q) + g);
		vx = (longint'(vx_q) * longint'({48'd0, damp_q})) >>> 16;
		vy = (vy * longint'({48'd0, damp_q})) >>> 16;
		px = clamp32(longint'(px_q) + ((vx * ldt) >>> 16));
		py = clamp32(longint'(py_q) + ((vy * ldt) >>> 16));
		dx = px - longint'(ax);
		dy = py - longint'(ay);
		ux = dx < 0 ? -dx : dx;
		uy = dy < 0 ? -dy : dy;
		taut = 1'b0;
		if (ux >= 64'h80000000 || uy >= 64'h80000000) begin
			taut = 1'b1;
			ux = ux >> 1;
			uy = uy >> 1;
		end else if (ux * ux + uy * uy > len * len) begin
			taut = 1'b1;
		end
		if (taut) begin
			d = root64(ux * ux + uy * uy);
			if (d == 0) d = 1;
			dirx = longint'((ux << 16) / d);
			diry = longint'((uy << 16) / d);
			if (dx < 0) dirx = -dirx;
			if (dy < 0) diry = -diry;
			px = clamp32(longint'(ax) + ((dirx * longint'(len)) >>> 16));
			py = clamp32(longint'(ay) + ((diry * longint'(len)) >>> 16));
			dot = (vx * dirx + vy * diry) >>> 16;
			vx = clamp32(vx - ((dot * dirx) >>> 16));
			vy = clamp32(vy - ((dot * diry) >>> 16));
		end
		px_q = px[31:0];
		py_q = py[31:0];
		vx_q = vx[31:0];
		vy_q = vy[31:0];
		r.px = px_q;
		r.py = py_q;
		r.vx = vx_q;
		r.vy = vy_q;
		r.taut = taut;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	// sends one word; valid stays up so a following word needs no drop
	task automatic send_word(input logic [15:0] dt, input logic signed [31:0] ax,
			input logic signed [31:0] ay);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		time_step <= dt;
		anchor_x <= ax;
		anchor_y <= ay;
		do @(posedge clk); while (in_stall);
		expected_q.push_back(swing_step(dt, ax, ay));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_GRAVITY: gravity_q = val;
			CFG_ROPE:    rope_q = val;
			CFG_DAMP:    damp_q = val[15:0];
			default: ;
		endcase
	endtask

	function automatic logic signed [31:0] near(input logic signed [31:0] p, input int span);
		return clamp32(longint'(p) + longint'($urandom_range(0, 2 * span)) - span);
	endfunction

	// out of reset: plain swing with the default registers
	task automatic test_reset_swing();
		repeat (6) send_word(16'd1092, 32'sd0, 32'sd0);
		send_word(16'd0, 32'sd0, 32'sd0);
		send_word(16'hFFFF, 32'sd0, 32'sd0);
		drain();
	endtask

	task automatic test_special_cases();
		send_word(16'd0, px_q, py_q);              // particle on the anchor
		send_word(16'hFFFF, 32'sh80000000, 32'sh7FFFFFFF);  // far overflow
		send_word(16'hFFFF, 32'sh7FFFFFFF, 32'sh80000000);
		send_word(16'd100, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		drain();
		write_reg(CFG_ROPE, 31'd0);                // zero rope length
		send_word(16'd500, near(px_q, 4096), near(py_q, 4096));
		send_word(16'd0, px_q, py_q);
		send_word(16'd700, 32'sd1000, -32'sd1000);
		drain();
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_GRAVITY, 31'h7FFFFFFF);
		write_reg(CFG_ROPE, 31'h7FFFFFFF);
		write_reg(CFG_DAMP, 31'd65535);
		write_reg(CFG_UNUSED, 31'h5A5A5A5A);       // ignored
		repeat (4) send_word(16'hFFFF, 32'sd0, 32'sd0);
		drain();
		write_reg(CFG_GRAVITY, 31'd0);
		write_reg(CFG_DAMP, 31'd0);
		write_reg(CFG_ROPE, 31'd1);
		send_word(16'hFFFF, 32'sd0, 32'sd0);
		send_word(16'd3000, 32'sh80000000, 32'sd0);
		drain();
		write_reg(CFG_GRAVITY, GRAVITY_RST);
		write_reg(CFG_ROPE, ROPE_RST);
		write_reg(CFG_DAMP, {15'd0, DAMP_RST});
	endtask

	task automatic test_random_swings();
		int span, sel;
		logic signed [31:0] ax, ay;
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			gaps_on = (ph != 7);
			sel = $urandom_range(0, 3);
			write_reg(CFG_GRAVITY, sel == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 24)));
			write_reg(CFG_ROPE, sel == 1 ? 31'($urandom) : 31'($urandom_range(1, 1 << 22)));
			write_reg(CFG_DAMP, sel == 2 ? 31'($urandom_range(0, 65535))
				: 31'($urandom_range(60000, 65535)));
			span = int'(rope_q > (1 << 24) ? (1 << 25) : rope_q * 2 + 8);
			for (int n = 0; n < 155; n++) begin
				sel = $urandom_range(0, 19);
				if (sel < 14) begin
					ax = near(px_q, span);
					ay = near(py_q, span);
				end else if (sel < 17) begin
					ax = $urandom;
					ay = $urandom;
				end else begin
					ax = $urandom_range(0, 4096) - 2048;
					ay = $urandom_range(0, 4096) - 2048;
				end
				send_word($urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000)),
					ax, ay);
				if (ph == 3) drain();                // sender waits for each answer
			end
		end
		drain();
	endtask

	always @(posedge clk) begin
		if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			out_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 9) == 0) begin
			stall_cnt <= $urandom_range(0, 15);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		particle_t w;
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report("unexpected word", position_x, 32'd0);
			end else begin
				w = expected_q.pop_front();
				if (position_x !== w.px) report("position_x", position_x, w.px);
				if (position_y !== w.py) report("position_y", position_y, w.py);
				if (velocity_x !== w.vx) report("velocity_x", velocity_x, w.vx);
				if (velocity_y !== w.vy) report("velocity_y", velocity_y, w.vy);
				if (rope_taut !== w.taut) report("rope_taut", {31'd0, rope_taut}, {31'd0, w.taut});
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cnt <= 0;
		end else if (idle_cnt == STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
	end

	initial begin
		gravity_q = GRAVITY_RST;
		rope_q = ROPE_RST;
		damp_q = DAMP_RST;
		px_q = '0;
		py_q = POS_Y_RST;
		vx_q = '0;
		vy_q = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_swing();
		test_special_cases();
		test_register_extremes();
		test_random_swings();
		repeat (100) @(posedge clk);
		if (fails == 0 && expected_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/prp_pkg.sv
rtl/core/pendulum_rope_particle_step.sv
dv/pendulum_rope_particle_step_test.sv
